/* hw/rtl/mfqs_pkg.sv */
package mfqs_pkg;

  // default sizes
  localparam int unsigned LevelsDef  = 3;
  localparam int unsigned JobsDef    = 16;
  localparam int unsigned LenBitsDef = 16;

  // fixed field widths
  localparam int unsigned IdW     = 4;
  localparam int unsigned LenW    = 16;
  localparam int unsigned PeriodW = 16;

  localparam logic [PeriodW-1:0] PeriodReset = 16'd20;

  // register indexes
  localparam logic RegPeriod = 1'b0;

  // input kinds
  localparam logic ActArrive = 1'b0;
  localparam logic ActTick   = 1'b1;

  // result status codes
  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusIdle   = 2'd1;
  localparam logic [1:0] StatusReject = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REQUEUE,
    S_PICK,
    S_LOAD,
    S_RUN,
    S_BST_POP,
    S_BST_PUSH,
    S_BST_RUN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic arrive;
    logic requeue;
    logic pick;
    logic load;
    logic run;
    logic bst_pop;
    logic bst_push;
    logic bst_run;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
    logic run_valid;
    logic any_queued;
    logic boost_fire;
    logic bst_more;
  } status_t;

endpackage

/* hw/rtl/mfqs_ctrl.sv */
module mfqs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_action_i,
  output logic              in_ready_o,
  input  mfqs_pkg::status_t st_i,
  output mfqs_pkg::cmd_t    cmd_o
);

  mfqs_pkg::state_e state_q, state_d;
  logic accept;

  assign in_ready_o = (state_q == mfqs_pkg::S_IDLE) && !st_i.out_busy;
  assign accept     = in_ready_o && in_valid_i;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfqs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mfqs_pkg::S_IDLE: begin
        if (accept && in_action_i == mfqs_pkg::ActTick) begin
          state_d = st_i.run_valid ? mfqs_pkg::S_REQUEUE : mfqs_pkg::S_PICK;
        end
      end
      mfqs_pkg::S_REQUEUE: state_d = mfqs_pkg::S_PICK;
      mfqs_pkg::S_PICK: begin
        state_d = st_i.any_queued ? mfqs_pkg::S_LOAD : mfqs_pkg::S_IDLE;
      end
      mfqs_pkg::S_LOAD: state_d = mfqs_pkg::S_RUN;
      mfqs_pkg::S_RUN: begin
        state_d = st_i.boost_fire ? mfqs_pkg::S_BST_POP : mfqs_pkg::S_IDLE;
      end
      mfqs_pkg::S_BST_POP: begin
        state_d = st_i.bst_more ? mfqs_pkg::S_BST_PUSH : mfqs_pkg::S_BST_RUN;
      end
      mfqs_pkg::S_BST_PUSH: state_d = mfqs_pkg::S_BST_POP;
      mfqs_pkg::S_BST_RUN: state_d = mfqs_pkg::S_IDLE;
      default: state_d = mfqs_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.arrive   = accept && (in_action_i == mfqs_pkg::ActArrive);
    case (state_q)
      mfqs_pkg::S_REQUEUE:  cmd_o.requeue  = 1'b1;
      mfqs_pkg::S_PICK:     cmd_o.pick     = 1'b1;
      mfqs_pkg::S_LOAD:     cmd_o.load     = 1'b1;
      mfqs_pkg::S_RUN:      cmd_o.run      = 1'b1;
      mfqs_pkg::S_BST_POP:  cmd_o.bst_pop  = 1'b1;
      mfqs_pkg::S_BST_PUSH: cmd_o.bst_push = 1'b1;
      mfqs_pkg::S_BST_RUN:  cmd_o.bst_run  = 1'b1;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/mfqs_datapath.sv */
module mfqs_datapath #(
  parameter int unsigned LEVELS   = mfqs_pkg::LevelsDef,
  parameter int unsigned JOBS     = mfqs_pkg::JobsDef,
  parameter int unsigned LEN_BITS = mfqs_pkg::LenBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mfqs_pkg::cmd_t               cmd_i,
  output mfqs_pkg::status_t            st_o,
  input  logic [mfqs_pkg::IdW-1:0]     in_id_i,
  input  logic [mfqs_pkg::LenW-1:0]    in_len_i,
  input  logic [mfqs_pkg::PeriodW-1:0] period_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [1:0]                   out_status_o,
  output logic [3:0]                   out_job_o,
  output logic [1:0]                   out_level_o,
  output logic                         out_fin_o,
  output logic                         out_boost_o
);

  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned JW = $clog2(JOBS);
  localparam int unsigned CW = $clog2(JOBS + 1);
  localparam int unsigned QA = $clog2(LEVELS * JOBS);
  localparam int unsigned QD = LEVELS * JOBS;
  localparam logic [LEN_BITS-1:0] LenMax = {LEN_BITS{1'b1}};

  typedef struct packed {
    logic [LW-1:0]       level;
    logic [LEN_BITS-1:0] ticks;
  } lt_t;

  typedef struct packed {
    logic [LEN_BITS-1:0] elapsed;
    logic [LEN_BITS-1:0] need;
  } en_t;

  // queue bookkeeping
  logic [CW-1:0] cnt_q  [LEVELS];
  logic [CW-1:0] cnt_d  [LEVELS];
  logic [JW-1:0] head_q [LEVELS];
  logic [JW-1:0] head_d [LEVELS];

  // memories
  logic [JW-1:0] q_mem [QD];
  logic [JW-1:0] q_rd_q;
  lt_t           lt_mem [JOBS];
  lt_t           lt_rd_q;
  en_t           en_mem [JOBS];
  en_t           en_rd_q;

  logic [JOBS-1:0] act_q;
  logic            run_v_q;
  logic [JW-1:0]   run_id_q;
  logic [mfqs_pkg::PeriodW-1:0] phase_q;

  logic       out_valid_q;
  logic [1:0] out_status_q;
  logic [3:0] out_job_q;
  logic [1:0] out_level_q;
  logic       out_fin_q, out_boost_q;

  // level selection
  logic          any_q, bst_more;
  logic [LW-1:0] pick_lv, bst_lv, pop_lv;
  logic          pop_en;
  logic [QA-1:0] q_ra;

  always_comb begin
    any_q    = 1'b0;
    pick_lv  = '0;
    bst_more = 1'b0;
    bst_lv   = '0;
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if (cnt_q[lv] != '0) begin
        any_q   = 1'b1;
        pick_lv = LW'(lv);
        if (lv != 0) begin
          bst_more = 1'b1;
          bst_lv   = LW'(lv);
        end
      end
    end
  end

  assign pop_lv = cmd_i.bst_pop ? bst_lv : pick_lv;
  assign pop_en = (cmd_i.pick && any_q) || (cmd_i.bst_pop && bst_more);
  assign q_ra   = QA'(pop_lv) * QA'(JOBS) + QA'(head_q[pop_lv]);

  // arrival check
  logic [JW-1:0] in_id;
  logic          reject, arrive_ok;

  assign in_id     = JW'(in_id_i);
  assign reject    = (32'(in_id_i) >= 32'(JOBS)) || act_q[in_id] ||
                     (32'(cnt_q[0]) >= 32'(JOBS));
  assign arrive_ok = cmd_i.arrive && !reject;

  // requeue decision
  logic          demote;
  logic [LW-1:0] lv_up;

  assign lv_up  = lt_rd_q.level + LW'(1);
  assign demote = (lt_rd_q.ticks >= LEN_BITS'(lt_rd_q.level) + LEN_BITS'(1)) &&
                  (32'(lt_rd_q.level) + 32'd1 < 32'(LEVELS));

  // run step
  logic [LEN_BITS-1:0]          el_n, tk_n;
  logic                         fin;
  logic [mfqs_pkg::PeriodW-1:0] phase_n;
  logic                         boost_fire;

  assign el_n       = (en_rd_q.elapsed == LenMax) ? en_rd_q.elapsed
                                                  : en_rd_q.elapsed + LEN_BITS'(1);
  assign tk_n       = (lt_rd_q.ticks == LenMax) ? lt_rd_q.ticks
                                                : lt_rd_q.ticks + LEN_BITS'(1);
  assign fin        = el_n >= en_rd_q.need;
  assign phase_n    = phase_q + mfqs_pkg::PeriodW'(1);
  assign boost_fire = phase_n >= period_i;

  // push port and per-job write ports
  logic          push_en, push_ok;
  logic [LW-1:0] push_lv;
  logic [JW-1:0] push_id, slot;
  logic [JW:0]   slot_sum;
  logic [QA-1:0] q_wa;
  logic          lt_we, en_we;
  logic [JW-1:0] lt_wa, en_wa;
  lt_t           lt_wd;
  en_t           en_wd;

  always_comb begin
    push_en = 1'b0;
    push_lv = '0;
    push_id = run_id_q;
    lt_we   = 1'b0;
    lt_wa   = run_id_q;
    lt_wd   = '0;
    en_we   = 1'b0;
    en_wa   = run_id_q;
    en_wd   = '0;
    if (arrive_ok) begin
      push_en = 1'b1;
      push_id = in_id;
      lt_we   = 1'b1;
      lt_wa   = in_id;
      en_we   = 1'b1;
      en_wa   = in_id;
      en_wd   = '{elapsed: '0, need: LEN_BITS'(in_len_i)};
    end
    if (cmd_i.requeue) begin
      push_en = 1'b1;
      push_lv = demote ? lv_up : lt_rd_q.level;
      if (demote) begin
        lt_we = 1'b1;
        lt_wd = '{level: lv_up, ticks: '0};
      end
    end
    if (cmd_i.run) begin
      lt_we = 1'b1;
      lt_wd = '{level: lt_rd_q.level, ticks: tk_n};
      en_we = 1'b1;
      en_wd = '{elapsed: el_n, need: en_rd_q.need};
    end
    if (cmd_i.bst_push) begin
      push_en = 1'b1;
      push_id = q_rd_q;
      lt_we   = 1'b1;
      lt_wa   = q_rd_q;
    end
    if (cmd_i.bst_run && run_v_q) begin
      push_en = 1'b1;
      lt_we   = 1'b1;
    end
  end

  assign push_ok  = push_en && (32'(cnt_q[push_lv]) < 32'(JOBS));
  assign slot_sum = (JW+1)'(head_q[push_lv]) + (JW+1)'(cnt_q[push_lv]);
  assign slot     = (32'(slot_sum) >= 32'(JOBS)) ? JW'(slot_sum - (JW+1)'(JOBS))
                                                  : JW'(slot_sum);
  assign q_wa     = QA'(push_lv) * QA'(JOBS) + QA'(slot);

  // queue pointer update
  always_comb begin
    for (int lv = 0; lv < LEVELS; lv++) begin
      cnt_d[lv]  = cnt_q[lv];
      head_d[lv] = head_q[lv];
      if (push_ok && push_lv == LW'(lv)) begin
        cnt_d[lv] = cnt_q[lv] + CW'(1);
      end else if (pop_en && pop_lv == LW'(lv)) begin
        cnt_d[lv] = cnt_q[lv] - CW'(1);
      end
      if (pop_en && pop_lv == LW'(lv)) begin
        head_d[lv] = (32'(head_q[lv]) + 32'd1 >= 32'(JOBS)) ? '0
                                                             : head_q[lv] + JW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int lv = 0; lv < LEVELS; lv++) begin
        cnt_q[lv]  <= '0;
        head_q[lv] <= '0;
      end
    end else begin
      for (int lv = 0; lv < LEVELS; lv++) begin
        cnt_q[lv]  <= cnt_d[lv];
        head_q[lv] <= head_d[lv];
      end
    end
  end

  // queue memory
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_mem[q_wa] <= push_id;
    end
    q_rd_q <= q_mem[q_ra];
  end

  // per-job memories, read at the running job or the job just popped
  logic [JW-1:0] j_ra;
  assign j_ra = cmd_i.load ? q_rd_q : run_id_q;

  always_ff @(posedge clk_i) begin
    if (lt_we) begin
      lt_mem[lt_wa] <= lt_wd;
    end
    lt_rd_q <= lt_mem[j_ra];
  end

  always_ff @(posedge clk_i) begin
    if (en_we) begin
      en_mem[en_wa] <= en_wd;
    end
    en_rd_q <= en_mem[j_ra];
  end

  // running job and busy-tick counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= '0;
      run_v_q <= 1'b0;
      phase_q <= '0;
    end else begin
      if (arrive_ok) begin
        act_q[in_id] <= 1'b1;
      end
      if (cmd_i.requeue || cmd_i.bst_run) begin
        run_v_q <= 1'b0;
      end
      if (cmd_i.run) begin
        run_v_q <= !fin;
        if (fin) begin
          act_q[run_id_q] <= 1'b0;
        end
        phase_q <= boost_fire ? '0 : phase_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      run_id_q <= q_rd_q;
    end
  end

  // result word
  logic emit;
  assign emit = cmd_i.arrive || (cmd_i.pick && !any_q) ||
                (cmd_i.run && !boost_fire) || cmd_i.bst_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.arrive || cmd_i.pick) begin
      out_status_q <= cmd_i.arrive ? (reject ? mfqs_pkg::StatusReject
                                             : mfqs_pkg::StatusOk)
                                   : mfqs_pkg::StatusIdle;
      out_job_q    <= '0;
      out_level_q  <= '0;
      out_fin_q    <= 1'b0;
      out_boost_q  <= 1'b0;
    end else if (cmd_i.run) begin
      out_status_q <= mfqs_pkg::StatusOk;
      out_job_q    <= 4'(run_id_q);
      out_level_q  <= 2'(lt_rd_q.level);
      out_fin_q    <= fin;
      out_boost_q  <= boost_fire;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_job_o    = out_job_q;
  assign out_level_o  = out_level_q;
  assign out_fin_o    = out_fin_q;
  assign out_boost_o  = out_boost_q;

  assign st_o.out_busy   = out_valid_q;
  assign st_o.run_valid  = run_v_q;
  assign st_o.any_queued = any_q;
  assign st_o.boost_fire = boost_fire;
  assign st_o.bst_more   = bst_more;

endmodule

/* hw/rtl/multilevel_feedback_queue_scheduler.sv */
// Multilevel feedback queue scheduler.
// Input word: s_tuser is the kind (0 arrival, 1 tick); s_tdata carries the
// arriving job's id and length. Output word: m_tuser is the status
// (0 ok, 1 idle tick, 2 arrival rejected); m_tdata carries the job that ran,
// its level, a finished flag and a boost flag.
// An arrival is handled in the cycle it is taken; its word shows in the
// next cycle. A tick passes through the requeue state (when a job was
// running and is put back into a queue), pick, load and run before its word
// shows; its word follows pick when no job is queued. A boost tick then pops
// each job in the lower queues and pushes it to the top queue through the
// shared queue memory port and puts back the running job before its word shows.
// One item is in work at a time; s_tready is low while a tick runs and while
// the output word waits to be taken, so a stalled receiver holds the block.
// Reset empties all queues, clears the running job and the busy-tick counter,
// and loads reset_period with 20. reset_period sits at APB address 0; the
// user must write it only while the block is idle; no logic enforces this.
module multilevel_feedback_queue_scheduler #(
  parameter int unsigned LEVELS   = mfqs_pkg::LevelsDef,
  parameter int unsigned JOBS     = mfqs_pkg::JobsDef,
  parameter int unsigned LEN_BITS = mfqs_pkg::LenBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // job_id[3:0], job_length[19:4], zero pad
  input  logic        s_tuser,   // action[0]
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // ran_job[3:0], ran_level[5:4], job_finished[6],
                                 // boost_done[7]
  output logic [1:0]  m_tuser,   // status[1:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mfqs_pkg::cmd_t    cmd;
  mfqs_pkg::status_t st;
  logic [mfqs_pkg::PeriodW-1:0] period_q;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= mfqs_pkg::PeriodReset;
    end else if (psel && penable && pwrite && paddr[2] == mfqs_pkg::RegPeriod) begin
      period_q <= pwdata[mfqs_pkg::PeriodW-1:0];
    end
  end

  assign prdata = (paddr[2] == mfqs_pkg::RegPeriod) ? 32'(period_q) : '0;

  mfqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_action_i (s_tuser),
    .in_ready_o  (s_tready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  mfqs_datapath #(
    .LEVELS   (LEVELS),
    .JOBS     (JOBS),
    .LEN_BITS (LEN_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .in_id_i      (s_tdata[3:0]),
    .in_len_i     (s_tdata[19:4]),
    .period_i     (period_q),
    .out_ready_i  (m_tready),
    .out_valid_o  (m_tvalid),
    .out_status_o (m_tuser),
    .out_job_o    (m_tdata[3:0]),
    .out_level_o  (m_tdata[5:4]),
    .out_fin_o    (m_tdata[6]),
    .out_boost_o  (m_tdata[7])
  );

endmodule

/* tb/mfqs_checker.sv */
`timescale 1ns / 1ps

module mfqs_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // job_id[3:0], job_length[19:4], zero pad
  input  logic        s_tuser,   // action[0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // ran_job[3:0], ran_level[5:4], job_finished[6],
                                 // boost_done[7]
  input  logic [1:0]  m_tuser,   // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_cnt,
  output int          pending,
  output int          words_seen,
  output int          boosts_seen,
  output int          retires_seen
);

  localparam int NLev = 3;
  localparam int NJob = 16;

  typedef struct packed {
    logic [1:0] status;
    logic       boost;
    logic       fin;
    logic [1:0] lvl;
    logic [3:0] job;
  } sched_word_t;

  // shadow scheduler state
  logic [3:0]  lvl_fifo [NLev][NJob];
  int          lvl_head [NLev];
  int          lvl_cnt  [NLev];
  logic [1:0]  job_lvl  [NJob];
  logic [15:0] job_slice[NJob];
  logic [15:0] job_done [NJob];
  logic [15:0] job_len  [NJob];
  logic        job_live [NJob];
  logic        cur_valid;
  logic [3:0]  cur_job;
  logic [15:0] busy_ticks;
  logic [15:0] period;

  sched_word_t sched_exp_q[$];

  function automatic void lvl_push(int lv, logic [3:0] id);
    if (lvl_cnt[lv] < NJob) begin
      lvl_fifo[lv][(lvl_head[lv] + lvl_cnt[lv]) % NJob] = id;
      lvl_cnt[lv]++;
    end
  endfunction

  function automatic logic [3:0] lvl_pop(int lv);
    logic [3:0] id;
    id = lvl_fifo[lv][lvl_head[lv]];
    lvl_head[lv] = (lvl_head[lv] + 1) % NJob;
    lvl_cnt[lv]--;
    return id;
  endfunction

  // schedule one word and return what the block must answer
  function automatic sched_word_t sched_predict(logic act, logic [23:0] d);
    sched_word_t r;
    logic [3:0]  id;
    int          lv;
    r = '0;
    r.status = mfqs_pkg::StatusOk;
    if (act == mfqs_pkg::ActArrive) begin
      id = d[3:0];
      if (job_live[id] || lvl_cnt[0] >= NJob) begin
        r.status = mfqs_pkg::StatusReject;
      end else begin
        job_lvl[id]   = 2'd0;
        job_slice[id] = '0;
        job_done[id]  = '0;
        job_len[id]   = d[19:4];
        job_live[id]  = 1'b1;
        lvl_push(0, id);
      end
    end else begin
      // put the previous job back, demoting when its slice is used up
      if (cur_valid) begin
        lv = job_lvl[cur_job];
        if (job_slice[cur_job] >= 16'(lv + 1) && lv + 1 < NLev) begin
          job_slice[cur_job] = '0;
          job_lvl[cur_job]   = 2'(lv + 1);
          lvl_push(lv + 1, cur_job);
        end else begin
          lvl_push(lv, cur_job);
        end
        cur_valid = 1'b0;
      end
      for (int l = 0; l < NLev; l++) begin
        if (!cur_valid && lvl_cnt[l] != 0) begin
          cur_job   = lvl_pop(l);
          cur_valid = 1'b1;
        end
      end
      if (!cur_valid) begin
        r.status = mfqs_pkg::StatusIdle;
      end else begin
        r.job = cur_job;
        r.lvl = job_lvl[cur_job];
        if (job_done[cur_job] != 16'hFFFF) job_done[cur_job]++;
        if (job_slice[cur_job] != 16'hFFFF) job_slice[cur_job]++;
        if (job_done[cur_job] >= job_len[cur_job]) begin
          r.fin = 1'b1;
          job_live[cur_job] = 1'b0;
          cur_valid = 1'b0;
        end
        busy_ticks++;
        if (busy_ticks >= period) begin
          busy_ticks = '0;
          r.boost = 1'b1;
          // sweep lower levels in order, then the running job
          for (int l = 1; l < NLev; l++) begin
            while (lvl_cnt[l] != 0) begin
              id = lvl_pop(l);
              job_lvl[id] = 2'd0;
              job_slice[id] = '0;
              lvl_push(0, id);
            end
          end
          if (cur_valid) begin
            job_lvl[cur_job] = 2'd0;
            job_slice[cur_job] = '0;
            lvl_push(0, cur_job);
            cur_valid = 1'b0;
          end
        end
      end
    end
    return r;
  endfunction

  assign pending = sched_exp_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sched_word_t want;
    sched_word_t got;
    if (!rst_ni) begin
      for (int l = 0; l < NLev; l++) begin
        lvl_head[l] = 0;
        lvl_cnt[l]  = 0;
      end
      for (int j = 0; j < NJob; j++) job_live[j] = 1'b0;
      cur_valid  = 1'b0;
      cur_job    = '0;
      busy_ticks = '0;
      period     = mfqs_pkg::PeriodReset;
      sched_exp_q.delete();
      fail_cnt     <= 0;
      words_seen   <= 0;
      boosts_seen  <= 0;
      retires_seen <= 0;
    end else begin
      // result word against the oldest prediction
      if (m_tvalid && m_tready) begin
        got.status = m_tuser;
        got.job    = m_tdata[3:0];
        got.lvl    = m_tdata[5:4];
        got.fin    = m_tdata[6];
        got.boost  = m_tdata[7];
        words_seen <= words_seen + 1;
        if (sched_exp_q.size() == 0) begin
          $error("unexpected result word %h/%h", m_tuser, m_tdata);
          fail_cnt <= fail_cnt + 1;
        end else begin
          want = sched_exp_q.pop_front();
          if (want != got) fail_cnt <= fail_cnt + 1;
          if (want.status != got.status)
            $error("status: expected %0d got %0d", want.status, got.status);
          if (want.job != got.job)
            $error("ran_job: expected %0d got %0d", want.job, got.job);
          if (want.lvl != got.lvl)
            $error("ran_level: expected %0d got %0d", want.lvl, got.lvl);
          if (want.fin != got.fin)
            $error("job_finished: expected %0d got %0d", want.fin, got.fin);
          if (want.boost != got.boost)
            $error("boost_done: expected %0d got %0d", want.boost, got.boost);
          if (want.boost) boosts_seen <= boosts_seen + 1;
          if (want.fin) retires_seen <= retires_seen + 1;
        end
      end
      // accepted input word
      if (s_tvalid && s_tready) sched_exp_q.push_back(sched_predict(s_tuser, s_tdata));
      // register write
      if (psel && penable && pwrite && pready && paddr == {mfqs_pkg::RegPeriod, 2'b00})
        period = pwdata[15:0];
    end
  end

endmodule

/* tb/tb_multilevel_feedback_queue_scheduler.sv */
`timescale 1ns / 1ps

module tb_multilevel_feedback_queue_scheduler;

  localparam int CycleLimit = 1000000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // job_id[3:0], job_length[19:4], zero pad
  logic        s_tuser;   // action[0]
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [7:0]  m_tdata;   // ran_job[3:0], ran_level[5:4], job_finished[6], boost_done[7]
  logic [1:0]  m_tuser;   // status[1:0]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int  fail_cnt;
  int  pending;
  int  words_seen;
  int  boosts_seen;
  int  retires_seen;
  int  cycles = 0;
  logic word_taken;
  logic gaps_on;
  logic long_jobs;

  multilevel_feedback_queue_scheduler dut (
    .clk_i, .rst_ni,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mfqs_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_cnt, .pending, .words_seen, .boosts_seen, .retires_seen
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // input handshake seen at the edge, read back at the falling edge
  always @(posedge clk_i) word_taken <= s_tvalid && s_tready;

  // receiver stalls
  always @(negedge clk_i) begin
    m_tready <= !(gaps_on && $urandom_range(99) < 35);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_word(logic act, logic [3:0] id, logic [15:0] len);
    while (gaps_on && $urandom_range(99) < 35) begin
      s_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = {4'b0, len, id};
    do @(negedge clk_i); while (!word_taken);
    s_tvalid = 1'b0;
  endtask

  // write reset_period once the block has gone quiet
  task automatic set_period(logic [15:0] val);
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    paddr   = {mfqs_pkg::RegPeriod, 2'b00};
    pwdata  = {16'h0, val};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic random_words(int n);
    logic [15:0] len;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 40) begin
        if (long_jobs && $urandom_range(99) < 6) len = 16'($urandom());
        else if ($urandom_range(99) < 4) len = '0;
        else len = 16'($urandom_range(12, 1));
        send_word(mfqs_pkg::ActArrive, 4'($urandom_range(15)), len);
      end else begin
        send_word(mfqs_pkg::ActTick, 4'($urandom()), 16'($urandom()));
      end
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    s_tvalid  = 1'b0;
    s_tuser   = mfqs_pkg::ActArrive;
    s_tdata   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    gaps_on   = 1'b1;
    long_jobs = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: idle tick, zero length, duplicate, extremes of id, demotion
    send_word(mfqs_pkg::ActTick, 4'hF, 16'hFFFF);
    send_word(mfqs_pkg::ActArrive, 4'd0, 16'd0);
    send_word(mfqs_pkg::ActArrive, 4'd0, 16'd5);
    send_word(mfqs_pkg::ActTick, 4'd0, 16'd0);
    send_word(mfqs_pkg::ActArrive, 4'd15, 16'd1);
    send_word(mfqs_pkg::ActArrive, 4'd5, 16'd9);
    send_word(mfqs_pkg::ActArrive, 4'd6, 16'd7);
    send_word(mfqs_pkg::ActArrive, 4'd5, 16'd2);
    for (int i = 0; i < 16; i++) send_word(mfqs_pkg::ActTick, 4'd0, 16'd0);

    // default period, then the extremes and a zero period
    random_words(330);
    set_period(16'd1);
    gaps_on = 1'b0;
    random_words(250);
    gaps_on = 1'b1;
    set_period(16'hFFFF);
    random_words(250);
    set_period(16'd0);
    random_words(200);
    set_period(16'($urandom_range(30, 2)));
    long_jobs = 1'b1;
    random_words(330);

    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    $display("checked %0d result words over 5 period settings", words_seen);
    $display("%0d job retirements and %0d priority boosts", retires_seen, boosts_seen);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
